// ===== hdl/segint_pkg.sv =====
// Shared types and constants for the segment intersection block.
// Used by the front end, the divider back end, the top level and the checker.
package segint_pkg;

  typedef enum logic [1:0] {
    OUTCOME_POINT   = 2'd0,
    OUTCOME_NONE    = 2'd1,
    OUTCOME_OVERLAP = 2'd2
  } outcome_e;

  localparam int unsigned LimitBits = 10;
  localparam int unsigned OutBits   = 27;
  localparam logic [LimitBits-1:0] LimitReset = 10'd20;

endpackage

// ===== hdl/segment_intersection.sv =====
// Segment intersection top level: front end, queue, divider back end, output register.
// Depends on segint_pkg, segint_front, segint_fifo and segint_div.
//
// Usage: present two segments on the in channel (in_valid_i/in_ready_o).
// The front end forms the Cramer numerators and denominator in four stages
// and classifies the pair; a queue decouples it from a bit-per-stage
// divider of 27 stages behind an input register. Results leave on the out
// channel (out_valid_o/out_ready_i) with outcome_o, point_x_o and point_y_o.
// Throughput is one transaction per cycle while the receiver keeps up;
// a result passes through four front stages, the queue and 28 divider
// registers on its way to the output.
// The user writes the coordinate bound on cfg_valid_i/cfg_ready_o only while idle;
// it is unenforced. Reset empties all stages and the queue and sets the bound to 20.
// When the receiver stalls, the divider and output hold; the front end keeps
// accepting while the queue holds at most three entries, four if f_valid is low.
module segment_intersection #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [segint_pkg::LimitBits-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [COORD_BITS-1:0] a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [1:0] outcome_o,
  output logic signed [segint_pkg::OutBits-1:0] point_x_o,
  output logic signed [segint_pkg::OutBits-1:0] point_y_o
);
  localparam int unsigned NB = 4 * COORD_BITS + 4;
  localparam int unsigned FQ = 8;
  localparam int unsigned FW = 2 + 3 * NB;
  localparam int unsigned CW = $clog2(FQ + 1);

  logic [segint_pkg::LimitBits-1:0] limit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= segint_pkg::LimitReset;
    else if (cfg_valid_i) limit_q <= cfg_data_i;
  end
  assign cfg_ready_o = 1'b1;

  logic f_adv, f_valid;
  segint_pkg::outcome_e f_oc;
  logic signed [NB-1:0] f_xn, f_yn;
  logic [NB-1:0] f_dn;
  logic [CW-1:0] q_cnt;
  logic q_empty, q_pop;
  logic [FW-1:0] q_rd;
  logic [2:0] f_inflight;

  // Stall the front end when the queue could not absorb what it holds.
  assign f_inflight = 3'(f_valid) + 3'd4;
  assign f_adv = (32'(q_cnt) + 32'(f_inflight)) <= FQ;

  segint_front #(.COORD_BITS(COORD_BITS), .NUM_BITS(NB)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .x1_i(a_start_x_i), .y1_i(a_start_y_i), .x2_i(a_end_x_i), .y2_i(a_end_y_i),
    .x3_i(b_start_x_i), .y3_i(b_start_y_i), .x4_i(b_end_x_i), .y4_i(b_end_y_i),
    .adv_i(f_adv), .valid_o(f_valid), .outcome_o(f_oc),
    .xnum_o(f_xn), .ynum_o(f_yn), .den_o(f_dn)
  );

  segint_fifo #(.WIDTH(FW), .DEPTH(FQ)) u_fifo (
    .clk_i, .rst_ni, .push_i(f_valid && f_adv), .wdata_i({f_oc, f_xn, f_yn, f_dn}),
    .pop_i(q_pop), .rdata_o(q_rd), .empty_o(q_empty), .count_o(q_cnt)
  );

  logic b_adv, b_valid;
  segint_pkg::outcome_e b_oc;
  logic [segint_pkg::OutBits-1:0] b_px, b_py;

  assign b_adv = !out_valid_o || out_ready_i;
  assign q_pop = b_adv && !q_empty;

  segint_div #(.NUM_BITS(NB), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .adv_i(b_adv), .valid_i(q_pop),
    .outcome_i(segint_pkg::outcome_e'(q_rd[FW-1 -: 2])),
    .xnum_i(q_rd[3*NB-1 -: NB]), .ynum_i(q_rd[2*NB-1 -: NB]), .den_i(q_rd[NB-1:0]),
    .limit_i(limit_q), .valid_o(b_valid), .outcome_o(b_oc), .px_o(b_px), .py_o(b_py)
  );

  // The divider's last stage is the output register; it holds under stall.
  assign out_valid_o = b_valid;
  assign outcome_o   = b_oc;
  assign point_x_o   = b_px;
  assign point_y_o   = b_py;
endmodule

// ===== hdl/segint_front.sv =====
// Front end: cross products, denominator sign fix, exact box test.
// Four register stages; depends on segint_pkg.
module segint_front #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned NUM_BITS   = 4 * COORD_BITS + 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [COORD_BITS-1:0] x1_i, y1_i, x2_i, y2_i,
  input  logic signed [COORD_BITS-1:0] x3_i, y3_i, x4_i, y4_i,
  input  logic                        adv_i,
  output logic                        valid_o,
  output segint_pkg::outcome_e        outcome_o,
  output logic signed [NUM_BITS-1:0]  xnum_o,
  output logic signed [NUM_BITS-1:0]  ynum_o,
  output logic        [NUM_BITS-1:0]  den_o
);
  localparam int unsigned DB = COORD_BITS + 1;
  localparam int unsigned CB = 2 * COORD_BITS + 1;

  // The whole front pipeline moves together when adv_i is high.
  assign in_ready_o = adv_i;

  // Stage 1: differences, the two line constants and the per-segment extents.
  logic v1_q;
  logic signed [DB-1:0] dxa_q, dya_q, dxb_q, dyb_q;
  logic signed [CB-1:0] ca_q, cb_q;
  logic signed [COORD_BITS-1:0] mnxa_q, mxxa_q, mnya_q, mxya_q;
  logic signed [COORD_BITS-1:0] mnxb_q, mxxb_q, mnyb_q, mxyb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv_i) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dxa_q <= DB'(x1_i) - DB'(x2_i);
      dya_q <= DB'(y1_i) - DB'(y2_i);
      dxb_q <= DB'(x3_i) - DB'(x4_i);
      dyb_q <= DB'(y3_i) - DB'(y4_i);
      ca_q  <= CB'(x1_i) * CB'(y2_i) - CB'(y1_i) * CB'(x2_i);
      cb_q  <= CB'(x3_i) * CB'(y4_i) - CB'(y3_i) * CB'(x4_i);
      mnxa_q <= (x1_i < x2_i) ? x1_i : x2_i;
      mxxa_q <= (x1_i > x2_i) ? x1_i : x2_i;
      mnya_q <= (y1_i < y2_i) ? y1_i : y2_i;
      mxya_q <= (y1_i > y2_i) ? y1_i : y2_i;
      mnxb_q <= (x3_i < x4_i) ? x3_i : x4_i;
      mxxb_q <= (x3_i > x4_i) ? x3_i : x4_i;
      mnyb_q <= (y3_i < y4_i) ? y3_i : y4_i;
      mxyb_q <= (y3_i > y4_i) ? y3_i : y4_i;
    end
  end

  // Box bounds: tighter of the two segments per axis.
  logic signed [COORD_BITS-1:0] lox, hix, loy, hiy;
  always_comb begin
    lox = (mnxa_q > mnxb_q) ? mnxa_q : mnxb_q;
    hix = (mxxa_q < mxxb_q) ? mxxa_q : mxxb_q;
    loy = (mnya_q > mnyb_q) ? mnya_q : mnyb_q;
    hiy = (mxya_q < mxyb_q) ? mxya_q : mxyb_q;
  end

  // Stage 2: numerators, denominator, box bounds and the empty-box flag.
  logic v2_q;
  logic signed [NUM_BITS-1:0] xn2_q, yn2_q, dn2_q;
  logic signed [COORD_BITS-1:0] lox2_q, hix2_q, loy2_q, hiy2_q;
  logic empty2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv_i) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      xn2_q <= NUM_BITS'(ca_q) * NUM_BITS'(dxb_q) - NUM_BITS'(dxa_q) * NUM_BITS'(cb_q);
      yn2_q <= NUM_BITS'(ca_q) * NUM_BITS'(dyb_q) - NUM_BITS'(dya_q) * NUM_BITS'(cb_q);
      dn2_q <= NUM_BITS'(dxa_q) * NUM_BITS'(dyb_q) - NUM_BITS'(dya_q) * NUM_BITS'(dxb_q);
      lox2_q <= lox; hix2_q <= hix; loy2_q <= loy; hiy2_q <= hiy;
      empty2_q <= (lox > hix) || (loy > hiy);
    end
  end

  // Stage 3: normalize the sign and scale the bounds.
  logic v3_q, zero3_q, empty3_q;
  logic signed [NUM_BITS-1:0] xn3_q, yn3_q, dn3_q;
  logic signed [NUM_BITS-1:0] lx3_q, hx3_q, ly3_q, hy3_q;
  logic                        neg2;
  logic signed [NUM_BITS-1:0] dabs;

  assign neg2 = dn2_q[NUM_BITS-1];
  assign dabs = neg2 ? -dn2_q : dn2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv_i) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      zero3_q  <= (dn2_q == '0);
      empty3_q <= empty2_q;
      xn3_q    <= neg2 ? -xn2_q : xn2_q;
      yn3_q    <= neg2 ? -yn2_q : yn2_q;
      dn3_q    <= dabs;
      lx3_q    <= NUM_BITS'(lox2_q) * dabs;
      hx3_q    <= NUM_BITS'(hix2_q) * dabs;
      ly3_q    <= NUM_BITS'(loy2_q) * dabs;
      hy3_q    <= NUM_BITS'(hiy2_q) * dabs;
    end
  end

  // Stage 4: classification.
  logic v4_q;
  segint_pkg::outcome_e oc_q;
  logic signed [NUM_BITS-1:0] xn4_q, yn4_q;
  logic [NUM_BITS-1:0] dn4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv_i) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (zero3_q) begin
        oc_q <= (xn3_q == '0 && yn3_q == '0) ? segint_pkg::OUTCOME_OVERLAP
                                             : segint_pkg::OUTCOME_NONE;
      end else if (empty3_q || xn3_q < lx3_q || xn3_q > hx3_q ||
                   yn3_q < ly3_q || yn3_q > hy3_q) begin
        oc_q <= segint_pkg::OUTCOME_NONE;
      end else begin
        oc_q <= segint_pkg::OUTCOME_POINT;
      end
      xn4_q <= xn3_q;
      yn4_q <= yn3_q;
      dn4_q <= NUM_BITS'(dn3_q);
    end
  end

  assign valid_o   = v4_q;
  assign outcome_o = oc_q;
  assign xnum_o    = xn4_q;
  assign ynum_o    = yn4_q;
  assign den_o     = dn4_q;
endmodule

// ===== hdl/segint_fifo.sv =====
// Short queue between the front end and the divider back end.
// Holds classified transactions; depends on segint_pkg only through its users.
module segint_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
endmodule

// ===== hdl/segint_div.sv =====
// Back end: pipelined restoring divider, one quotient bit per stage, for x and y.
// Emits the fixed point result or the sentinel; depends on segint_pkg.
module segint_div #(
  parameter int unsigned NUM_BITS  = 48,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  segint_pkg::outcome_e       outcome_i,
  input  logic signed [NUM_BITS-1:0] xnum_i,
  input  logic signed [NUM_BITS-1:0] ynum_i,
  input  logic        [NUM_BITS-1:0] den_i,
  input  logic [segint_pkg::LimitBits-1:0] limit_i,
  output logic                       valid_o,
  output segint_pkg::outcome_e       outcome_o,
  output logic [segint_pkg::OutBits-1:0] px_o,
  output logic [segint_pkg::OutBits-1:0] py_o
);
  localparam int unsigned OB = segint_pkg::OutBits;
  // Quotient needs only OB bits: the point lies within the coordinate box.
  localparam int unsigned NS = OB;
  localparam int unsigned DW = NUM_BITS + FRAC_BITS;

  typedef struct packed {
    logic                 neg;
    logic [DW-1:0]        rem;
    logic [OB-1:0]        quo;
  } lane_t;

  typedef struct packed {
    segint_pkg::outcome_e oc;
    logic [OB-1:0]        sent;
    logic [DW-1:0]        den;
    lane_t                lx;
    lane_t                ly;
  } stage_t;

  logic [NS:0] vld_q;
  stage_t st_q [NS+1];

  function automatic lane_t div_step(lane_t l, logic [DW-1:0] d, int unsigned b);
    logic [DW-1:0] t;
    lane_t r;
    t = (b < DW) ? (d << b) : '0;
    r = l;
    if ((b < DW) && ((d >> (DW - 1 - b)) <= 1) && (l.rem >= t) &&
        ((b == 0) || ((d >> (DW - b)) == '0))) begin
      r.rem = l.rem - t;
      r.quo[b] = 1'b1;
    end
    return r;
  endfunction

  logic [NUM_BITS-1:0] ax, ay;
  assign ax = xnum_i[NUM_BITS-1] ? NUM_BITS'(-xnum_i) : NUM_BITS'(xnum_i);
  assign ay = ynum_i[NUM_BITS-1] ? NUM_BITS'(-ynum_i) : NUM_BITS'(ynum_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv_i) vld_q <= {vld_q[NS-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0].oc     <= outcome_i;
      st_q[0].sent   <= OB'({limit_i, FRAC_BITS'(0)} +
                         ((outcome_i == segint_pkg::OUTCOME_OVERLAP ? 2 : 1) << FRAC_BITS));
      st_q[0].den    <= DW'(den_i);
      st_q[0].lx.neg <= xnum_i[NUM_BITS-1];
      st_q[0].lx.rem <= DW'(ax) << FRAC_BITS;
      st_q[0].lx.quo <= '0;
      st_q[0].ly.neg <= ynum_i[NUM_BITS-1];
      st_q[0].ly.rem <= DW'(ay) << FRAC_BITS;
      st_q[0].ly.quo <= '0;
      // Stage g+1 decides quotient bit NS-1-g.
      for (int g = 0; g < NS; g++) begin
        st_q[g+1].oc   <= st_q[g].oc;
        st_q[g+1].sent <= st_q[g].sent;
        st_q[g+1].den  <= st_q[g].den;
        st_q[g+1].lx   <= div_step(st_q[g].lx, st_q[g].den, unsigned'(NS - 1 - g));
        st_q[g+1].ly   <= div_step(st_q[g].ly, st_q[g].den, unsigned'(NS - 1 - g));
      end
    end
  end

  logic [OB-1:0] qx, qy;
  assign qx = st_q[NS].lx.neg ? -st_q[NS].lx.quo : st_q[NS].lx.quo;
  assign qy = st_q[NS].ly.neg ? -st_q[NS].ly.quo : st_q[NS].ly.quo;

  assign valid_o   = vld_q[NS];
  assign outcome_o = st_q[NS].oc;
  assign px_o = (st_q[NS].oc == segint_pkg::OUTCOME_POINT) ? qx : st_q[NS].sent;
  assign py_o = (st_q[NS].oc == segint_pkg::OUTCOME_POINT) ? qy : st_q[NS].sent;
endmodule

// ===== hdl/segint_checker.sv =====
// Port-level checker for the segment intersection block, bound to the top level.
// Depends on segint_pkg for the outcome codes.
module segint_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [1:0] outcome_o,
  input logic [26:0] point_x_o,
  input logic [26:0] point_y_o
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(point_x_o))
    else $error("output changed under stall");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outcome_o != 2'd3)
    else $error("bad outcome code");
  a_sentinel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o != segint_pkg::OUTCOME_POINT |-> point_x_o == point_y_o)
    else $error("sentinel fields differ");
endmodule

bind segment_intersection segint_checker u_checker (.*);

// ===== verif/segment_intersection_tb.sv =====
// Testbench for segment_intersection: drives segment pairs, predicts each result
// from exact integer arithmetic and checks it. Depends on segint_pkg and the RTL.
`timescale 1ns / 1ps

module segment_intersection_tb;

  localparam int CB = 11;
  localparam int FB = 16;
  localparam int OB = segint_pkg::OutBits;

  typedef struct {
    segint_pkg::outcome_e outcome;
    logic [OB-1:0] px;
    logic [OB-1:0] py;
  } isect_t;

  typedef logic signed [CB-1:0] coord_t;

  class isect_scoreboard;
    isect_t pending[$];
    logic [segint_pkg::LimitBits-1:0] limit;
    int mismatches;

    function new();
      limit = segint_pkg::LimitReset;
      mismatches = 0;
    endfunction

    function logic [OB-1:0] fixdiv(longint num, longint den);
      longint a;
      longint mag;
      a = (num < 0) ? -num : num;
      mag = ((a / den) << FB) + (((a % den) << FB) / den);
      if (num < 0) mag = -mag;
      return mag[OB-1:0];
    endfunction

    function logic [OB-1:0] sentinel(int add);
      longint v;
      v = (longint'(limit) + add) << FB;
      return v[OB-1:0];
    endfunction

    // Works out the result of one accepted transaction and queues it.
    function void note_segments(coord_t c[8]);
      longint x1, y1, x2, y2, x3, y3, x4, y4;
      longint dxa, dya, dxb, dyb, ca, cb, xn, yn, den;
      isect_t r;
      x1 = c[0]; y1 = c[1]; x2 = c[2]; y2 = c[3];
      x3 = c[4]; y3 = c[5]; x4 = c[6]; y4 = c[7];
      dxa = x1 - x2; dya = y1 - y2; dxb = x3 - x4; dyb = y3 - y4;
      ca = x1 * y2 - y1 * x2;
      cb = x3 * y4 - y3 * x4;
      xn = ca * dxb - dxa * cb;
      yn = ca * dyb - dya * cb;
      den = dxa * dyb - dya * dxb;
      if (den == 0) begin
        if (xn == 0 && yn == 0) begin
          r.outcome = segint_pkg::OUTCOME_OVERLAP;
          r.px = sentinel(2);
        end else begin
          r.outcome = segint_pkg::OUTCOME_NONE;
          r.px = sentinel(1);
        end
        r.py = r.px;
      end else begin
        if (den < 0) begin
          den = -den; xn = -xn; yn = -yn;
        end
        if (xn < ((x1 < x2) ? x1 : x2) * den || xn > ((x1 > x2) ? x1 : x2) * den ||
            xn < ((x3 < x4) ? x3 : x4) * den || xn > ((x3 > x4) ? x3 : x4) * den ||
            yn < ((y1 < y2) ? y1 : y2) * den || yn > ((y1 > y2) ? y1 : y2) * den ||
            yn < ((y3 < y4) ? y3 : y4) * den || yn > ((y3 > y4) ? y3 : y4) * den) begin
          r.outcome = segint_pkg::OUTCOME_NONE;
          r.px = sentinel(1);
          r.py = r.px;
        end else begin
          r.outcome = segint_pkg::OUTCOME_POINT;
          r.px = fixdiv(xn, den);
          r.py = fixdiv(yn, den);
        end
      end
      pending.insert(pending.size(), r);
    endfunction

    function void fail_report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [1:0] oc, logic [OB-1:0] px, logic [OB-1:0] py);
      isect_t e;
      if (pending.size() == 0) begin
        fail_report($sformatf("unexpected result outcome=%0d x=%h y=%h", oc, px, py));
        return;
      end
      e = pending.pop_front();
      if (oc !== e.outcome || px !== e.px || py !== e.py)
        fail_report($sformatf("expected outcome=%0d x=%h y=%h, got outcome=%0d x=%h y=%h",
                              e.outcome, e.px, e.py, oc, px, py));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [segint_pkg::LimitBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t a_start_x_i = '0, a_start_y_i = '0, a_end_x_i = '0, a_end_y_i = '0;
  coord_t b_start_x_i = '0, b_start_y_i = '0, b_end_x_i = '0, b_end_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] outcome_o;
  logic signed [OB-1:0] point_x_o, point_y_o;

  isect_scoreboard sb = new();
  bit idle_free = 1'b0;

  segment_intersection #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, results checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(outcome_o, point_x_o, point_y_o);
  end

  always @(negedge clk_i) begin
    out_ready_i <= idle_free || ($urandom_range(99) >= 17);
  end

  // Called at a falling edge; valid stays high between back-to-back transactions.
  task automatic send_segments(coord_t c[8]);
    while (!idle_free && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i} <= {c[0], c[1], c[2], c[3]};
    {b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i} <= {c[4], c[5], c[6], c[7]};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_segments(c);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [segint_pkg::LimitBits-1:0] lim);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.limit = lim;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_list(int v0, int v1, int v2, int v3, int v4, int v5, int v6, int v7);
    coord_t c[8];
    c = '{coord_t'(v0), coord_t'(v1), coord_t'(v2), coord_t'(v3),
          coord_t'(v4), coord_t'(v5), coord_t'(v6), coord_t'(v7)};
    send_segments(c);
  endtask

  // Mostly small coordinates so that crossings fall inside the boxes.
  task automatic send_random(int span);
    coord_t c[8];
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(9))
        0: c[k] = coord_t'($urandom);
        1: c[k] = ($urandom_range(1)) ? coord_t'(-1024) : coord_t'(1023);
        default: c[k] = coord_t'($signed($urandom_range(2 * span)) - span);
      endcase
    end
    // Sometimes force parallel or collinear geometry.
    if ($urandom_range(9) == 0) begin
      c[6] = coord_t'(c[4] + (c[2] - c[0]));
      c[7] = coord_t'(c[5] + (c[3] - c[1]));
    end else if ($urandom_range(9) == 0) begin
      c[4] = coord_t'(c[0] + 2 * (c[2] - c[0]));
      c[5] = coord_t'(c[1] + 2 * (c[3] - c[1]));
      c[6] = coord_t'(c[0] - (c[2] - c[0]));
      c[7] = coord_t'(c[1] - (c[3] - c[1]));
    end
    send_segments(c);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: crossing, touching ends, parallel, collinear disjoint, extremes.
    send_list(0, 0, 10, 10, 0, 10, 10, 0);
    send_list(0, 0, 3, 1, 0, 1, 1, 0);
    send_list(-5, -5, 5, 5, 5, -5, -5, 5);
    send_list(0, 0, 4, 0, 4, 0, 4, 4);
    send_list(0, 0, 4, 4, 0, 1, 4, 5);
    send_list(0, 0, 1, 1, 5, 5, 7, 7);
    send_list(0, 0, 1, 1, 0, 0, 1, 1);
    send_list(0, 0, 1, 0, 3, -1, 3, 1);
    send_list(3, 3, 3, 3, 3, 3, 3, 3);
    send_list(-1024, -1024, 1023, 1023, -1024, 1023, 1023, -1024);
    send_list(-1024, 1023, 1023, -1024, 1023, 1023, -1024, -1024);
    send_list(-1024, 0, 1023, 1, 0, -1024, 1, 1023);
    send_list(1023, 1023, -1024, -1024, 1023, -1024, -1024, 1023);
    send_list(-1, -1, -7, -3, -2, -5, -6, 0);
    send_list(0, 0, 7, 3, 1, 5, 6, -4);
    write_limit(10'd0);
    send_list(0, 0, 1, 1, 2, 0, 3, 1);
    send_list(0, 0, 1, 1, 2, 2, 3, 3);
    write_limit(10'd1021);
    send_list(0, 0, 1, 1, 2, 0, 3, 1);
    send_list(0, 0, 1, 1, 2, 2, 3, 3);

    for (int n = 0; n < 800; n++) begin
      if (n == 200) write_limit(10'($urandom_range(1021)));
      if (n == 400) begin
        write_limit(10'd0);
        idle_free = 1'b1;
      end
      if (n == 550) idle_free = 1'b0;
      if (n == 650) write_limit(10'd1021);
      send_random((n % 4 == 0) ? 1024 : 24);
    end

    drain_results();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
